@@ rtl/core/csvu_pkg.sv @@
package csvu_pkg;

  // default sizes handed to the top level
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int WIDTH_BITS_DEF  = 16;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // input item kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_SEED  = 2'd2;

  // operations queued for the back part
  localparam logic [1:0] OP_BYTES = 2'd0;  // one to four printable bytes
  localparam logic [1:0] OP_DROP  = 2'd1;  // last byte of a field that prints nothing
  localparam logic [1:0] OP_EMPTY = 2'd2;  // empty field
  localparam logic [1:0] OP_SEED  = 2'd3;  // seed a column width

  typedef struct packed {
    logic [1:0]      kind;
    logic [3:0][7:0] bytes;
    logic [1:0]      nb_m1;
    logic            first;
    logic            last;
    logic [5:0]      column;
    logic [15:0]     seed;
  } op_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic        end_of_field;
    logic [15:0] field_width;
    logic [15:0] column_width;
  } res_t;

endpackage

@@ rtl/core/csv_field_unescape_width.sv @@
// path: input -> op queue -> current op register -> result queue -> outputs
// throughput: one input item per cycle while in_full is low; the single back-end
//   result sequencer sends an expansion one byte at a time (four for a hex escape)
// reset: synchronous active-low rst_n empties both queues, clears quote state and the
//   field width, and clears all column width valid bits at once (no clearing pass)
module csv_field_unescape_width #(
  parameter int MAX_COLUMNS = csvu_pkg::MAX_COLUMNS_DEF,
  parameter int WIDTH_BITS  = csvu_pkg::WIDTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_field,
  input  logic        in_last_of_field,
  input  logic [5:0]  in_column,
  input  logic [15:0] in_seed_width,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last_of_run,
  output logic        out_end_of_field,
  output logic [15:0] out_field_width,
  output logic [15:0] out_column_width
);
  import csvu_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_nempty;
  op_t  push_op;
  op_t  head_op;
  res_t res;

  // front: accept and classify
  csvu_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .in_first_of_field (in_first_of_field),
    .in_last_of_field  (in_last_of_field),
    .in_column         (in_column),
    .in_seed_width     (in_seed_width),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_op              (push_op)
  );

  // op queue between front and back
  csvu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .nempty  (q_nempty),
    .head_op (head_op)
  );

  // back: emit results and track widths
  csvu_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .WIDTH_BITS  (WIDTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (q_nempty),
    .q_head    (head_op),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign in_full          = q_full;
  assign out_byte         = res.out_byte;
  assign out_byte_valid   = res.byte_valid;
  assign out_last_of_run  = res.last_of_run;
  assign out_end_of_field = res.end_of_field;
  assign out_field_width  = res.field_width;
  assign out_column_width = res.column_width;

endmodule

@@ rtl/core/csvu_front.sv @@
module csvu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic [1:0]       in_kind,
  input  logic [7:0]       in_data_byte,
  input  logic             in_first_of_field,
  input  logic             in_last_of_field,
  input  logic [5:0]       in_column,
  input  logic [15:0]      in_seed_width,
  input  logic             q_full,
  output logic             q_push,
  output csvu_pkg::op_t    q_op
);
  import csvu_pkg::*;

  logic       iq_r, iq_nxt;
  logic       sq_r, sq_nxt;
  logic       clr_r, clr_nxt;
  logic       iq, sq;
  logic       accept;
  logic       enq;
  logic [2:0] n;
  logic [7:0] letter;
  op_t        op;

  // hex digit in upper case
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      hex_digit = 8'h30 + {4'h0, v};
    end else begin
      hex_digit = 8'h41 + {4'h0, v - 4'd10};
    end
  endfunction

  assign accept = in_push && !q_full;

  // letter for the named control escapes, zero for the rest
  always_comb begin
    case (in_data_byte)
      8'h07:   letter = 8'h61;
      8'h08:   letter = 8'h62;
      8'h09:   letter = 8'h74;
      8'h0A:   letter = 8'h6E;
      8'h0B:   letter = 8'h76;
      8'h0C:   letter = 8'h66;
      8'h0D:   letter = 8'h72;
      8'h1B:   letter = 8'h65;
      default: letter = 8'h00;
    endcase
  end

  // classify the item and expand its printable bytes
  always_comb begin
    op        = '0;
    n         = 3'd0;
    enq       = 1'b0;
    iq_nxt    = iq_r;
    sq_nxt    = sq_r;
    clr_nxt   = clr_r;
    iq        = in_first_of_field ? 1'b0 : iq_r;
    sq        = in_first_of_field ? 1'b0 : sq_r;
    op.first  = in_first_of_field || clr_r;
    op.last   = in_last_of_field;
    op.column = in_column;
    op.seed   = in_seed_width;
    unique case (in_kind)
      KIND_BYTE: begin
        iq_nxt = iq;
        sq_nxt = sq;
        if (in_first_of_field && in_data_byte == 8'h22) begin
          iq_nxt = 1'b1;
        end else if (sq) begin
          sq_nxt = 1'b0;
        end else if (iq && in_data_byte == 8'h22) begin
          if (!in_last_of_field) begin
            op.bytes[0] = 8'h22;
            n           = 3'd1;
            sq_nxt      = 1'b1;
          end
        end else if (in_data_byte == 8'h5C) begin
          op.bytes[0] = 8'h5C;
          op.bytes[1] = 8'h5C;
          n           = 3'd2;
        end else if (in_data_byte >= 8'h20 && in_data_byte != 8'h7F) begin
          op.bytes[0] = in_data_byte;
          n           = 3'd1;
        end else if (letter != 8'h00) begin
          op.bytes[0] = 8'h5C;
          op.bytes[1] = letter;
          n           = 3'd2;
        end else begin
          op.bytes[0] = 8'h5C;
          op.bytes[1] = 8'h78;
          op.bytes[2] = hex_digit(in_data_byte[7:4]);
          op.bytes[3] = hex_digit(in_data_byte[3:0]);
          n           = 3'd4;
        end
        // end of field clears quote tracking
        if (in_last_of_field) begin
          iq_nxt = 1'b0;
          sq_nxt = 1'b0;
        end
        if (n != 3'd0) begin
          op.kind  = OP_BYTES;
          op.nb_m1 = 2'(n - 3'd1);
          enq      = 1'b1;
        end else begin
          op.kind = OP_DROP;
          enq     = in_last_of_field;
        end
        // a dropped opening quote still restarts the width count downstream
        if (enq) begin
          clr_nxt = 1'b0;
        end else if (in_first_of_field) begin
          clr_nxt = 1'b1;
        end
      end
      KIND_EMPTY: begin
        iq_nxt  = 1'b0;
        sq_nxt  = 1'b0;
        clr_nxt = 1'b0;
        op.kind = OP_EMPTY;
        enq     = 1'b1;
      end
      KIND_SEED: begin
        op.kind  = OP_SEED;
        op.first = clr_r;
        clr_nxt  = 1'b0;
        enq      = 1'b1;
      end
      default: begin
        enq = 1'b0;
      end
    endcase
  end

  // quote state and pending width restart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iq_r  <= 1'b0;
      sq_r  <= 1'b0;
      clr_r <= 1'b0;
    end else if (accept) begin
      iq_r  <= iq_nxt;
      sq_r  <= sq_nxt;
      clr_r <= clr_nxt;
    end
  end

  assign q_push = accept && enq;
  assign q_op   = op;

endmodule

@@ rtl/core/csvu_queue.sv @@
module csvu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  csvu_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          nempty,
  output csvu_pkg::op_t head_op
);
  import csvu_pkg::*;

  op_t               ent_r [QDEPTH];
  logic [QAW-1:0]    wptr_r;
  logic [QAW-1:0]    rptr_r;
  logic [QAW:0]      cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == (QAW + 1)'(QDEPTH));
  assign nempty  = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && nempty;
  assign head_op = ent_r[rptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= push_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/csvu_back.sv @@
module csvu_back #(
  parameter int MAX_COLUMNS = csvu_pkg::MAX_COLUMNS_DEF,
  parameter int WIDTH_BITS  = csvu_pkg::WIDTH_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nempty,
  input  csvu_pkg::op_t  q_head,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output csvu_pkg::res_t out_res
);
  import csvu_pkg::*;

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int XW = (CW > 6) ? CW : 6;
  localparam logic [WIDTH_BITS-1:0] WMAX = '1;

  // column width store with per-entry valid bits
  logic [WIDTH_BITS-1:0]  mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] vld_r;
  logic [WIDTH_BITS-1:0]  rd_r;
  logic                   rdv_r;

  op_t                    cur_r;
  logic                   cur_vld_r;
  logic [1:0]             idx_r;
  logic [WIDTH_BITS-1:0]  wc_r;

  res_t                   ofifo_r [2];
  logic                   owptr_r;
  logic                   orptr_r;
  logic [1:0]             ocnt_r;

  logic                   emit;
  logic                   done;
  logic                   load;
  logic [1:0]             last_idx;
  logic                   final_res;
  logic [WIDTH_BITS-1:0]  base;
  logic [WIDTH_BITS-1:0]  inc;
  logic [WIDTH_BITS-1:0]  fw;
  logic [WIDTH_BITS-1:0]  cv;
  logic [WIDTH_BITS-1:0]  mx;
  logic [WIDTH_BITS-1:0]  seed_sat;
  logic [WIDTH_BITS-1:0]  cw_val;
  logic [WIDTH_BITS-1:0]  wc_nxt;
  logic [XW-1:0]          cur_colx;
  logic [XW-1:0]          ld_colx;
  logic                   cur_ok;
  logic                   ld_ok;
  logic [CW-1:0]          wr_addr;
  logic [CW-1:0]          ld_addr;
  logic                   wr_en;
  logic [WIDTH_BITS-1:0]  wr_data;
  res_t                   res;

  // column decode for the current op and for the op being loaded
  assign cur_colx = XW'(cur_r.column);
  assign ld_colx  = XW'(q_head.column);
  assign cur_ok   = (32'(cur_colx) < 32'(MAX_COLUMNS));
  assign ld_ok    = (32'(ld_colx) < 32'(MAX_COLUMNS));
  assign wr_addr  = cur_colx[CW-1:0];
  assign ld_addr  = ld_colx[CW-1:0];

  // sequencing of results
  assign last_idx = (cur_r.kind == OP_BYTES) ? cur_r.nb_m1 : 2'd0;
  assign emit     = cur_vld_r && (ocnt_r != 2'd2);
  assign done     = emit && (idx_r == last_idx);
  assign load     = q_nempty && (!cur_vld_r || done);
  assign q_pop    = load;

  // width arithmetic and column update
  always_comb begin
    cv        = rdv_r ? rd_r : '0;
    seed_sat  = (32'(cur_r.seed) > 32'(WMAX)) ? WMAX : WIDTH_BITS'(cur_r.seed);
    base      = (cur_r.first && idx_r == 2'd0) ? '0 : wc_r;
    if (cur_r.kind == OP_EMPTY) begin
      base = '0;
    end
    inc       = (base != WMAX) ? base + 1'b1 : base;
    fw        = (cur_r.kind == OP_BYTES) ? inc : base;
    mx        = (fw > cv) ? fw : cv;
    final_res = 1'b0;
    cw_val    = cv;
    wc_nxt    = fw;
    res       = '0;
    unique case (cur_r.kind)
      OP_BYTES: begin
        final_res      = cur_r.last && (idx_r == last_idx);
        cw_val         = final_res ? mx : cv;
        res.out_byte   = cur_r.bytes[idx_r];
        res.byte_valid = 1'b1;
      end
      OP_DROP: begin
        final_res = 1'b1;
        cw_val    = mx;
      end
      OP_EMPTY: begin
        final_res = 1'b1;
        cw_val    = mx;
        wc_nxt    = '0;
      end
      OP_SEED: begin
        cw_val = seed_sat;
      end
      default: begin
        cw_val = cv;
      end
    endcase
    res.last_of_run  = (idx_r == last_idx);
    res.end_of_field = final_res;
    res.field_width  = 16'(fw);
    res.column_width = cur_ok ? 16'(cw_val) : 16'h0000;
  end

  assign wr_en   = emit && cur_ok && (final_res || cur_r.kind == OP_SEED);
  assign wr_data = cw_val;

  // store write and registered read with bypass of a same-cycle write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (load) begin
      if (wr_en && wr_addr == ld_addr) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= mem[ld_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (load) begin
        rdv_r <= ld_ok && ((wr_en && wr_addr == ld_addr) || vld_r[ld_addr]);
      end
    end
  end

  // current op and field width counter
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
      wc_r      <= '0;
    end else begin
      if (emit) begin
        wc_r <= wc_nxt;
      end
      if (load) begin
        cur_vld_r <= 1'b1;
        idx_r     <= 2'd0;
      end else if (done) begin
        cur_vld_r <= 1'b0;
        idx_r     <= 2'd0;
      end else if (emit) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (emit) begin
      ofifo_r[owptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= 1'b0;
      orptr_r <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      if (emit) begin
        owptr_r <= ~owptr_r;
      end
      if (out_pop && !out_empty) begin
        orptr_r <= ~orptr_r;
      end
      if (emit && !(out_pop && !out_empty)) begin
        ocnt_r <= ocnt_r + 1'b1;
      end else if (!emit && out_pop && !out_empty) begin
        ocnt_r <= ocnt_r - 1'b1;
      end
    end
  end

  assign out_empty = (ocnt_r == 2'd0);
  assign out_res   = ofifo_r[orptr_r];

endmodule
